// ----- hw/rtl/ffgpa_pkg.sv -----
// Package for the first-fit guarded pool allocator.
// Word types, status and command codes, controller states and the structs
// shared by the cell row and the top level. No dependencies.
package ffgpa_pkg;

    localparam int POOL_BYTES_DEF  = 64;
    localparam int GUARD_BYTES_DEF = 4;
    localparam int MAX_POOL_BYTES  = 4096;
    // width of every index and byte count inside the cell row
    localparam int PW = $clog2(MAX_POOL_BYTES + 1);

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_ILLEGAL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY,
        S_SETTLE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       cmd;
        logic [5:0] request_size;
        logic [5:0] block_address;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] granted_address;
        logic [6:0] free_total;
        logic [6:0] largest_free;
        logic [6:0] smallest_free;
    } t_out_word;

    // control broadcast to every cell
    typedef struct packed {
        logic          do_alloc;
        logic          do_free;
        logic [PW-1:0] need;       // block length incl. guards
        logic [PW-1:0] claim_lo;
        logic [PW-1:0] claim_hi;
        logic [PW-1:0] start_at;   // payload offset of the new block
        logic [PW-1:0] free_at;    // payload offset named by a free
        logic [PW-1:0] clr_from;   // first byte of the block being freed
    } t_cell_ctl;

    // values a cell hands to its right neighbor every cycle
    typedef struct packed {
        logic [PW-1:0] run;        // free run ending at this byte
        logic          found;      // some byte at or left of here fits
        logic          clr;        // byte lies in the block being freed
        logic          is_end;     // end mark of this byte
        logic [PW-1:0] cnt;        // free bytes so far
        logic [PW-1:0] max_run;
        logic [PW-1:0] min_run;    // 0 while no run has closed
    } t_cell_link;

endpackage

// ----- hw/rtl/ffgpa_cell.sv -----
// One byte of the pool: occupancy, block-start and block-end marks plus the
// registered run, fit, clear and statistics chains. Depends on ffgpa_pkg.
module ffgpa_cell #(
    parameter int IDX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffgpa_pkg::t_cell_ctl  i_ctl,
    input  ffgpa_pkg::t_cell_link i_prev,
    input  logic                  i_next_used,
    output ffgpa_pkg::t_cell_link o_link,
    output logic                  o_used,
    output logic                  o_win,
    output logic                  o_start_hit
);
    import ffgpa_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic          r_used, r_start, r_end;
    logic [PW-1:0] r_run, r_cnt, r_max, r_min;
    logic          r_found, r_clr;

    logic          hit, run_end, claim;
    logic [PW-1:0] n_run, n_min;

    assign hit     = (r_run >= i_ctl.need);
    assign run_end = (r_run != '0) && i_next_used;
    assign claim   = i_ctl.do_alloc && (MY_IDX >= i_ctl.claim_lo) && (MY_IDX <= i_ctl.claim_hi);

    always_comb begin
        n_run = r_used ? '0 : i_prev.run + PW'(1);
        n_min = i_prev.min_run;
        if (run_end && (i_prev.min_run == '0 || r_run < i_prev.min_run)) begin
            n_min = r_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_start <= 1'b0;
            r_end   <= 1'b0;
            r_run   <= '0;
            r_cnt   <= '0;
            r_max   <= '0;
            r_min   <= '0;
            r_found <= 1'b0;
            r_clr   <= 1'b0;
        end else begin
            r_run   <= n_run;
            r_found <= i_prev.found || hit;
            r_clr   <= (MY_IDX == i_ctl.clr_from) || (i_prev.clr && !i_prev.is_end);
            r_cnt   <= i_prev.cnt + PW'(!r_used);
            r_max   <= (r_run > i_prev.max_run) ? r_run : i_prev.max_run;
            r_min   <= n_min;
            if (claim) begin
                r_used <= 1'b1;
            end else if (i_ctl.do_free && r_clr) begin
                r_used <= 1'b0;
            end
            if (i_ctl.do_alloc && MY_IDX == i_ctl.start_at) begin
                r_start <= 1'b1;
            end else if (i_ctl.do_free && MY_IDX == i_ctl.free_at) begin
                r_start <= 1'b0;
            end
            if (i_ctl.do_alloc && MY_IDX == i_ctl.claim_hi) begin
                r_end <= 1'b1;
            end else if (i_ctl.do_free && r_clr) begin
                r_end <= 1'b0;
            end
        end
    end

    assign o_link.run     = r_run;
    assign o_link.found   = r_found;
    assign o_link.clr     = r_clr;
    assign o_link.is_end  = r_end;
    assign o_link.cnt     = r_cnt;
    assign o_link.max_run = r_max;
    assign o_link.min_run = r_min;
    assign o_used         = r_used;
    // lowest byte that closes a fitting run
    assign o_win          = hit && !i_prev.found;
    assign o_start_hit    = r_start && (MY_IDX == i_ctl.free_at);

endmodule

// ----- hw/rtl/first_fit_guarded_pool_allocator_unit.sv -----
// First-fit guarded pool allocator: one result word per input word.
// From input accept to output valid the controller walks S_SEARCH, S_APPLY, S_SETTLE
// and S_DONE, as the cell row settles once before and once after the map update.
// One word in flight; a new word is taken only once the result is loaded and the controller is idle again.
// Synchronous active-low reset frees the whole pool; no clearing pass.
// Depends on ffgpa_pkg and ffgpa_cell.
module first_fit_guarded_pool_allocator_unit #(
    parameter int POOL_BYTES  = ffgpa_pkg::POOL_BYTES_DEF,
    parameter int GUARD_BYTES = ffgpa_pkg::GUARD_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ffgpa_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ffgpa_pkg::t_out_word o_out_word
);
    import ffgpa_pkg::*;

    localparam logic [PW-1:0] WAIT_LAST = PW'(POOL_BYTES + 1);
    localparam logic [PW-1:0] POOL_LEN  = PW'(POOL_BYTES);
    localparam logic [PW-1:0] GUARD2    = PW'(2 * GUARD_BYTES);
    localparam logic [PW-1:0] GUARD1    = PW'(GUARD_BYTES);

    t_state        r_state, n_state;
    logic [PW-1:0] r_wait;
    t_in_word      r_req;
    t_status       r_status;
    logic [PW-1:0] r_grant;
    logic          r_out_valid;
    t_out_word     r_out;

    t_cell_ctl     ctl;
    t_cell_link    links [POOL_BYTES+1];
    logic          used  [POOL_BYTES+1];
    logic [POOL_BYTES-1:0] win, start_hit;

    logic [PW-1:0] need, win_idx, claim_lo;
    logic          oversize, any_win, free_ok, alloc_ok;
    logic          accept, go_apply, load_out;

    // chain edges: nothing to the left, a used byte past the right end
    assign links[0] = '0;
    assign used[POOL_BYTES] = 1'b1;

    for (genvar g = 0; g < POOL_BYTES; g++) begin : g_cell
        ffgpa_cell #(.IDX(g)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_prev      (links[g]),
            .i_next_used (used[g+1]),
            .o_link      (links[g+1]),
            .o_used      (used[g]),
            .o_win       (win[g]),
            .o_start_hit (start_hit[g])
        );
    end

    assign need     = PW'(r_req.request_size) + GUARD2;
    assign oversize = (r_req.request_size == '0) || (need > POOL_LEN);

    always_comb begin
        win_idx = '0;
        for (int k = 0; k < POOL_BYTES; k++) begin
            if (win[k]) begin
                win_idx = win_idx | PW'(k);
            end
        end
    end

    assign any_win  = |win;
    assign free_ok  = |start_hit;
    assign alloc_ok = !oversize && any_win;
    assign claim_lo = win_idx + PW'(1) - need;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_SEARCH;
            S_SEARCH: if (r_wait == WAIT_LAST) n_state = S_APPLY;
            S_APPLY:  n_state = S_SETTLE;
            S_SETTLE: if (r_wait == WAIT_LAST) n_state = S_DONE;
            S_DONE:   if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        o_in_stall = 1'b1;
        go_apply   = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            S_IDLE:   o_in_stall = 1'b0;
            S_APPLY:  go_apply = 1'b1;
            S_DONE:   load_out = !r_out_valid || !i_out_stall;
            default:  o_in_stall = 1'b1;
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;

    assign ctl.do_alloc = go_apply && (r_req.cmd == CMD_ALLOC) && alloc_ok;
    assign ctl.do_free  = go_apply && (r_req.cmd == CMD_FREE) && free_ok;
    assign ctl.need     = need;
    assign ctl.claim_lo = claim_lo;
    assign ctl.claim_hi = win_idx;
    assign ctl.start_at = claim_lo + GUARD1;
    assign ctl.free_at  = PW'(r_req.block_address);
    assign ctl.clr_from = PW'(r_req.block_address) - GUARD1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= (n_state != r_state) ? '0 : r_wait + PW'(1);
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_word;
        end
        if (go_apply) begin
            if (r_req.cmd == CMD_ALLOC) begin
                r_status <= alloc_ok ? ST_OK : ST_OOM;
                r_grant  <= alloc_ok ? claim_lo + GUARD1 : '0;
            end else begin
                r_status <= free_ok ? ST_OK : ST_ILLEGAL;
                r_grant  <= '0;
            end
        end
        if (load_out) begin
            r_out.status          <= r_status;
            r_out.granted_address <= r_grant[5:0];
            r_out.free_total      <= links[POOL_BYTES].cnt[6:0];
            r_out.largest_free    <= links[POOL_BYTES].max_run[6:0];
            r_out.smallest_free   <= links[POOL_BYTES].min_run[6:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ----- sim/tb_first_fit_guarded_pool_allocator_unit.sv -----
`timescale 1ns / 100ps
// Testbench for first_fit_guarded_pool_allocator_unit: directed and random alloc/free
// words, checked against an in-bench model of the three byte maps.
// Depends on ffgpa_pkg and the allocator RTL.
module tb_first_fit_guarded_pool_allocator_unit;
    import ffgpa_pkg::*;

    localparam int POOL        = POOL_BYTES_DEF;
    localparam int GUARD       = GUARD_BYTES_DEF;
    localparam int LATENCY     = 2 * POOL + 6;
    localparam int RANDOM_OPS  = 950;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct {
        t_in_word    w;
        int unsigned gap;        // idle cycles before this word is offered
        bit          drain;      // hold until every result is back
        bit          pick_live;  // free: aim at a live block when one exists
    } t_pending;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    first_fit_guarded_pool_allocator_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model of the pool
    bit [POOL-1:0] pool_used;
    bit [POOL-1:0] blk_start;
    bit [POOL-1:0] blk_end;

    t_pending    pending_q[$];
    t_out_word   report_q[$];
    t_pending    cur_job;
    bit          have_job;
    bit          word_taken;
    int unsigned words_total;
    int unsigned taken_cnt, got_cnt, mismatches, cycles;
    int unsigned n_grant, n_oom, n_freed, n_illegal, peak_used;

    function automatic void queue_word(t_cmd c, int unsigned size, int unsigned addr,
                                       int unsigned gap, bit drain, bit pick);
        t_pending p;
        p.w.cmd           = c;
        p.w.request_size  = 6'(size);
        p.w.block_address = 6'(addr);
        p.gap             = gap;
        p.drain           = drain;
        p.pick_live       = pick;
        pending_q.push_back(p);
    endfunction

    // Applies one word to the model and builds the result word it should give.
    task automatic apply_pool_op(input t_in_word w, output t_out_word r);
        int unsigned need, base, k, run, total, largest, smallest;
        bit fits, done;
        r = '0;
        if (w.cmd == CMD_ALLOC) begin
            need = w.request_size + 2 * GUARD;
            r.status = ST_OOM;
            done = 1'b0;
            if (w.request_size != 0 && need <= POOL) begin
                for (base = 0; base + need <= POOL && !done; base++) begin
                    fits = 1'b1;
                    for (k = 0; k < need; k++)
                        if (pool_used[base + k]) fits = 1'b0;
                    if (fits) begin
                        for (k = 0; k < need; k++)
                            pool_used[base + k] = 1'b1;
                        blk_start[base + GUARD]    = 1'b1;
                        blk_end[base + need - 1]   = 1'b1;
                        r.status          = ST_OK;
                        r.granted_address = 6'(base + GUARD);
                        done = 1'b1;
                    end
                end
            end
            if (done) n_grant++;
            else n_oom++;
        end else if (!blk_start[w.block_address]) begin
            r.status = ST_ILLEGAL;
            n_illegal++;
        end else begin
            blk_start[w.block_address] = 1'b0;
            k = (w.block_address >= GUARD) ? w.block_address - GUARD : 0;
            done = 1'b0;
            // clear through the first end mark, leading guard included
            for (; k < POOL && !done; k++) begin
                pool_used[k] = 1'b0;
                if (blk_end[k]) begin
                    blk_end[k] = 1'b0;
                    done = 1'b1;
                end
            end
            r.status = ST_OK;
            n_freed++;
        end

        run = 0;
        total = 0;
        largest = 0;
        smallest = 0;
        for (k = 0; k <= POOL; k++) begin
            if (k < POOL && !pool_used[k]) begin
                run++;
                total++;
            end else if (run != 0) begin
                if (run > largest) largest = run;
                if (smallest == 0 || run < smallest) smallest = run;
                run = 0;
            end
        end
        r.free_total    = 7'(total);
        r.largest_free  = 7'(largest);
        r.smallest_free = 7'(smallest);
        if (POOL - total > peak_used) peak_used = POOL - total;
    endtask

    // Driver: takes the next pending word once the offered one is gone.
    always @(negedge i_clk) begin : driver
        t_in_word    w;
        int unsigned live[$];
        int unsigned k;
        if (!i_rst_n || (i_in_valid && !word_taken)) begin
            // in reset, or the word is still stalled: hold it
        end else begin
            if (!have_job && pending_q.size() != 0) begin
                cur_job  = pending_q.pop_front();
                have_job = 1'b1;
            end
            if (have_job && cur_job.gap != 0) begin
                cur_job.gap--;
                i_in_valid <= 1'b0;
            end else if (have_job && cur_job.drain && report_q.size() != 0) begin
                i_in_valid <= 1'b0;
            end else if (have_job) begin
                w = cur_job.w;
                if (cur_job.pick_live) begin
                    live.delete();
                    for (k = 0; k < POOL; k++)
                        if (blk_start[k]) live.push_back(k);
                    if (live.size() != 0)
                        w.block_address = 6'(live[$urandom_range(live.size() - 1)]);
                end
                i_in_valid <= 1'b1;
                i_in_word  <= w;
                have_job   = 1'b0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: mostly short, a few long, one very long hold-off,
    // and a calm stretch with no stall at all.
    bit          long_hold_done;
    int unsigned hold_left, stall_left;
    always @(negedge i_clk) begin : receiver
        int unsigned roll;
        bit stall_n;
        if (hold_left != 0) begin
            hold_left--;
            stall_n = 1'b1;
        end else if (!long_hold_done && taken_cnt >= 250) begin
            long_hold_done = 1'b1;
            hold_left = 700;
            stall_n = 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            stall_n = 1'b1;
        end else if (got_cnt >= 500 && got_cnt < 600) begin
            stall_n = 1'b0;
        end else begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                stall_n = 1'b0;
            end else begin
                stall_n = 1'b1;
                stall_left = (roll < 96) ? $urandom_range(3) : $urandom_range(20, 80);
            end
        end
        i_out_stall <= stall_n;
    end

    // Monitor: checks the result word first, then takes in an accepted input word.
    always @(posedge i_clk) begin : monitor
        t_out_word want, r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_cnt++;
            if (report_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: st=%0d addr=%0d free=%0d big=%0d min=%0d",
                             o_out_word.status, o_out_word.granted_address,
                             o_out_word.free_total, o_out_word.largest_free,
                             o_out_word.smallest_free);
            end else begin
                want = report_q.pop_front();
                if (o_out_word.status !== want.status
                        || o_out_word.granted_address !== want.granted_address
                        || o_out_word.free_total !== want.free_total
                        || o_out_word.largest_free !== want.largest_free
                        || o_out_word.smallest_free !== want.smallest_free) begin
                    mismatches++;
                    // fields: status/addr/free/largest/smallest
                    if (mismatches <= 10)
                        $display("result %0d exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 got_cnt, want.status, want.granted_address,
                                 want.free_total, want.largest_free, want.smallest_free,
                                 o_out_word.status, o_out_word.granted_address,
                                 o_out_word.free_total, o_out_word.largest_free,
                                 o_out_word.smallest_free);
                end
            end
        end
        word_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (word_taken) begin
            apply_pool_op(i_in_word, r);
            report_q.push_back(r);
            taken_cnt++;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, report_q.size());
            $display("tb_first_fit_guarded_pool_allocator_unit: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned n, roll, g, gap, size;

        // directed: size extremes, exact fit, full pool, bad and double frees, hole reuse
        queue_word(CMD_ALLOC, 0, 0, 0, 0, 0);     // zero size
        queue_word(CMD_ALLOC, 63, 63, 0, 0, 0);   // far too large
        queue_word(CMD_ALLOC, 57, 0, 0, 0, 0);    // one byte too large with guards
        queue_word(CMD_ALLOC, 56, 0, 0, 0, 0);    // fills the pool exactly
        queue_word(CMD_ALLOC, 1, 0, 0, 0, 0);     // pool full
        queue_word(CMD_FREE, 63, 0, 0, 0, 0);     // guard byte, not a payload
        queue_word(CMD_FREE, 0, 63, 0, 0, 0);
        queue_word(CMD_FREE, 0, 4, 0, 0, 0);
        queue_word(CMD_FREE, 0, 4, 0, 0, 0);      // double free
        queue_word(CMD_ALLOC, 1, 63, 3, 1, 0);    // sender waits for an empty pipe
        queue_word(CMD_ALLOC, 2, 0, 0, 0, 0);
        queue_word(CMD_ALLOC, 3, 0, 0, 0, 0);
        queue_word(CMD_FREE, 0, 13, 0, 0, 0);
        queue_word(CMD_ALLOC, 2, 0, 0, 0, 0);     // refills the hole exactly
        queue_word(CMD_ALLOC, 3, 0, 0, 0, 0);
        queue_word(CMD_FREE, 0, 23, 0, 0, 0);
        queue_word(CMD_FREE, 0, 5, 0, 0, 0);      // inside a live block
        queue_word(CMD_ALLOC, 40, 0, 0, 0, 0);    // too few free bytes for the guarded block
        queue_word(CMD_FREE, 0, 13, 0, 0, 0);
        queue_word(CMD_FREE, 0, 4, 0, 0, 0);
        queue_word(CMD_FREE, 0, 34, 0, 0, 0);
        queue_word(CMD_ALLOC, 63, 0, 0, 0, 0);

        // random: mostly allocs and frees of live blocks, some stray frees
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (n >= 400 && n < 500) begin
                gap = 0;
            end else begin
                g = $urandom_range(99);
                gap = (g < 70) ? 0 : (g < 90) ? $urandom_range(1, 4) :
                      (g < 98) ? $urandom_range(5, 30) : $urandom_range(60, 200);
            end
            roll = $urandom_range(99);
            if (roll < 46) begin
                g = $urandom_range(99);
                size = (g < 2) ? 0 : (g < 80) ? $urandom_range(1, 12) :
                       (g < 95) ? $urandom_range(13, 30) : $urandom_range(31, 63);
                queue_word(CMD_ALLOC, size, $urandom_range(63), gap, n == 600, 0);
            end else begin
                queue_word(CMD_FREE, $urandom_range(63), $urandom_range(63), gap,
                           n == 600, roll < 90);
            end
        end
        words_total = pending_q.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (taken_cnt != words_total || report_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 16) @(posedge i_clk);

        $display("ran %0d words: %0d grants, %0d out of memory, %0d frees, %0d illegal frees",
                 taken_cnt, n_grant, n_oom, n_freed, n_illegal);
        $display("peak pool use %0d of %0d bytes, %0d mismatches", peak_used, POOL, mismatches);
        if (mismatches == 0) begin
            $display("tb_first_fit_guarded_pool_allocator_unit: PASS");
        end else begin
            $display("tb_first_fit_guarded_pool_allocator_unit: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ffgpa_pkg.sv
hw/rtl/ffgpa_cell.sv
hw/rtl/first_fit_guarded_pool_allocator_unit.sv
sim/tb_first_fit_guarded_pool_allocator_unit.sv
